[rtl/gmvs_pkg.sv]
// ----------------------------------------------------------------------------
// gmvs_pkg
// Shared types and constants of the grid mesh vertex sequencer.
// ----------------------------------------------------------------------------
package gmvs_pkg;

   localparam int MAX_CUTS_DEFAULT  = 255;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CFG_W       = 24;
   localparam int CUTS_W      = 8;
   localparam int IDX_W       = 17;
   localparam int VAL_W       = 32;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ASPECT        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_MARGIN = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTS_ACROSS   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTS_DEEP     = 4'd3;

   // aspect 1.0 in Q8.16
   localparam logic [CFG_W-1:0] ASPECT_RESET = 24'h01_0000;

   typedef struct packed {
      logic [CFG_W-1:0]  aspect;
      logic [CFG_W-1:0]  repeat_margin;
      logic [CUTS_W-1:0] cuts_across;
      logic [CUTS_W-1:0] cuts_deep;
   } gmvs_cfg_type;

   typedef struct packed {
      logic             busy;
      logic [VAL_W-1:0] step_x;
      logic [VAL_W-1:0] step_u;
      logic [VAL_W-1:0] step_depth;
      logic [VAL_W-1:0] row_x;
   } gmvs_setup_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] pos_x;
      logic signed [VAL_W-1:0] pos_z;
      logic signed [VAL_W-1:0] tex_u;
      logic signed [VAL_W-1:0] tex_v;
      logic [IDX_W-1:0]        vertex_number;
      logic                    quad_valid;
      logic [IDX_W-1:0]        corner_prev_left;
      logic [IDX_W-1:0]        corner_prev_right;
      logic [IDX_W-1:0]        corner_this_left;
      logic [IDX_W-1:0]        corner_this_right;
      logic                    final_vertex;
   } gmvs_result_type;

endpackage

[rtl/gmvs_req_if.sv]
// ----------------------------------------------------------------------------
// gmvs_req_if
// Request channel: one word per vertex, carrying the restart flag.
// ----------------------------------------------------------------------------
interface gmvs_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

[rtl/gmvs_rsp_if.sv]
// ----------------------------------------------------------------------------
// gmvs_rsp_if
// Response channel: one word per vertex with position, uv and quad corners.
// ----------------------------------------------------------------------------
interface gmvs_rsp_if;
   import gmvs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] pos_x;
   logic signed [VAL_W-1:0] pos_z;
   logic signed [VAL_W-1:0] tex_u;
   logic signed [VAL_W-1:0] tex_v;
   logic [IDX_W-1:0]        vertex_number;
   logic                    quad_valid;
   logic [IDX_W-1:0]        corner_prev_left;
   logic [IDX_W-1:0]        corner_prev_right;
   logic [IDX_W-1:0]        corner_this_left;
   logic [IDX_W-1:0]        corner_this_right;
   logic                    final_vertex;

   modport source (
      output valid, output pos_x, output pos_z, output tex_u, output tex_v,
      output vertex_number, output quad_valid, output corner_prev_left,
      output corner_prev_right, output corner_this_left,
      output corner_this_right, output final_vertex, input ready);
   modport sink (
      input valid, input pos_x, input pos_z, input tex_u, input tex_v,
      input vertex_number, input quad_valid, input corner_prev_left,
      input corner_prev_right, input corner_this_left,
      input corner_this_right, input final_vertex, output ready);
endinterface

[rtl/gmvs_csr_if.sv]
// ----------------------------------------------------------------------------
// gmvs_csr_if
// Register write channel: index and data, one word per register write.
// ----------------------------------------------------------------------------
interface gmvs_csr_if;
   import gmvs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/grid_mesh_vertex_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// grid_mesh_vertex_sequencer_unit
// Plane grid vertex sequencer: one vertex word per request word, with the
// quad corner indices, walking a (W+2) x (D+2) grid row by row.
// ----------------------------------------------------------------------------
// a vertex is registered onto the response port in the cycle after its request word is taken
// throughput: one vertex per cycle, limited by response back-pressure and by the set-up stall
// after a register write the request side stalls while the restoring dividers
// produce the steps, one quotient bit a cycle
// reset: registers at default values, steps ready, next word gives vertex 0
module grid_mesh_vertex_sequencer_unit #(
   parameter int MAX_CUTS  = gmvs_pkg::MAX_CUTS_DEFAULT,
   parameter int FRAC_BITS = gmvs_pkg::FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   gmvs_req_if.sink   req_port,
   gmvs_rsp_if.source rsp_port,
   gmvs_csr_if.sink   csr_port
);

   import gmvs_pkg::*;

   logic [CFG_W-1:0]  aspect_ff;
   logic [CFG_W-1:0]  repeat_margin_ff;
   logic [CUTS_W-1:0] cuts_across_ff;
   logic [CUTS_W-1:0] cuts_deep_ff;
   logic              csr_write;
   gmvs_cfg_type      cfg;
   gmvs_setup_type    setup;

   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         aspect_ff        <= ASPECT_RESET;
         repeat_margin_ff <= '0;
         cuts_across_ff   <= '0;
         cuts_deep_ff     <= '0;
      end else if (csr_write) begin
         case (csr_port.index)
            CSR_ASPECT: begin
               aspect_ff <= csr_port.data;
            end
            CSR_REPEAT_MARGIN: begin
               repeat_margin_ff <= csr_port.data;
            end
            CSR_CUTS_ACROSS: begin
               cuts_across_ff <= csr_port.data[CUTS_W-1:0];
            end
            CSR_CUTS_DEEP: begin
               cuts_deep_ff <= csr_port.data[CUTS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.aspect        = aspect_ff;
   assign cfg.repeat_margin = repeat_margin_ff;
   assign cfg.cuts_across   = cuts_across_ff;
   assign cfg.cuts_deep     = cuts_deep_ff;

   gmvs_setup #(.MAX_CUTS(MAX_CUTS), .FRAC_BITS(FRAC_BITS)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .cfg       (cfg),
      .setup     (setup)
   );

   gmvs_walker #(.MAX_CUTS(MAX_CUTS), .FRAC_BITS(FRAC_BITS)) u_walker (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .rsp   (rsp_port),
      .cfg   (cfg),
      .setup (setup)
   );

endmodule

[rtl/gmvs_divider.sv]
// ----------------------------------------------------------------------------
// gmvs_divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module gmvs_divider #(
   parameter int DIVIDEND_W = 34,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      fits     = (trial >= {1'b0, dsr_ff});
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[rtl/gmvs_setup.sv]
// ----------------------------------------------------------------------------
// gmvs_setup
// Step set-up: aspect product, row start x and the three step quotients,
// recomputed after every register write.
// ----------------------------------------------------------------------------
module gmvs_setup #(
   parameter int MAX_CUTS  = gmvs_pkg::MAX_CUTS_DEFAULT,
   parameter int FRAC_BITS = gmvs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  gmvs_pkg::gmvs_cfg_type  cfg,
   output gmvs_pkg::gmvs_setup_type setup
);

   import gmvs_pkg::*;

   localparam int UV_W      = ((FRAC_BITS > CFG_W + 1) ? FRAC_BITS : CFG_W + 1) + 1;
   localparam int PROD_W    = CFG_W + UV_W;
   localparam int XQ_W      = PROD_W - FRAC_BITS;
   localparam int DIV_W     = (XQ_W > VAL_W) ? XQ_W : VAL_W;
   localparam int EFF_CUTS  = (MAX_CUTS < 2**CUTS_W - 1) ? MAX_CUTS : 2**CUTS_W - 1;
   localparam int LAST_W    = $clog2(EFF_CUTS + 2);

   localparam logic [PROD_W-1:0] PROD_RESET   = PROD_W'(ASPECT_RESET) << FRAC_BITS;
   localparam logic [VAL_W-1:0]  STEP_X_RESET = VAL_W'(ASPECT_RESET);
   localparam logic [VAL_W-1:0]  ONE_STEP     = VAL_W'(1) << FRAC_BITS;
   localparam logic [DIV_W-1:0]  DEPTH_DIVIDEND = DIV_W'(1) << FRAC_BITS;
   localparam logic [63:0]       MAG_LIMIT    = 64'h0000_0000_8000_0000;

   logic [UV_W-1:0]   uv_width;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_ff;
   logic [LAST_W-1:0] width_div;
   logic [LAST_W-1:0] depth_div;
   logic              pending_ff;
   logic              run_ff;
   logic [VAL_W-1:0]  step_x_ff, step_u_ff, step_depth_ff;
   logic [DIV_W-1:0]  quo_x, quo_u, quo_d;
   logic              busy_x, busy_u, busy_d;
   logic              div_busy;
   logic [63:0]       mag;

   function automatic logic [VAL_W-1:0] sat_step(input logic [DIV_W-1:0] q);
      sat_step = (|q[DIV_W-1:VAL_W-1]) ? 32'h7FFF_FFFF : {1'b0, q[VAL_W-2:0]};
   endfunction

   always_comb begin
      uv_width  = (UV_W'(1) << FRAC_BITS) + UV_W'({cfg.repeat_margin, 1'b0});
      prod      = PROD_W'(cfg.aspect) * PROD_W'(uv_width);
      width_div = (32'(cfg.cuts_across) > MAX_CUTS) ? LAST_W'(EFF_CUTS + 1)
                                                   : LAST_W'(cfg.cuts_across) + 1'b1;
      depth_div = (32'(cfg.cuts_deep) > MAX_CUTS) ? LAST_W'(EFF_CUTS + 1)
                                                 : LAST_W'(cfg.cuts_deep) + 1'b1;
   end

   // x step: floor(prod / (wd << frac)) is floor((prod >> frac) / wd)
   gmvs_divider #(.DIVIDEND_W(DIV_W), .DIVISOR_W(LAST_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (pending_ff),
      .dividend (DIV_W'(prod >> FRAC_BITS)),
      .divisor  (width_div),
      .busy     (busy_x),
      .quotient (quo_x)
   );

   gmvs_divider #(.DIVIDEND_W(DIV_W), .DIVISOR_W(LAST_W)) u_div_u (
      .clock    (clock),
      .reset    (reset),
      .start    (pending_ff),
      .dividend (DIV_W'(uv_width)),
      .divisor  (width_div),
      .busy     (busy_u),
      .quotient (quo_u)
   );

   gmvs_divider #(.DIVIDEND_W(DIV_W), .DIVISOR_W(LAST_W)) u_div_d (
      .clock    (clock),
      .reset    (reset),
      .start    (pending_ff),
      .dividend (DEPTH_DIVIDEND),
      .divisor  (depth_div),
      .busy     (busy_d),
      .quotient (quo_d)
   );

   assign div_busy = busy_x | busy_u | busy_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 1'b0;
         run_ff        <= 1'b0;
         prod_ff       <= PROD_RESET;
         step_x_ff     <= STEP_X_RESET;
         step_u_ff     <= ONE_STEP;
         step_depth_ff <= ONE_STEP;
      end else begin
         pending_ff <= csr_write;
         prod_ff    <= prod;
         if (pending_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && !div_busy) begin
            run_ff        <= 1'b0;
            step_x_ff     <= sat_step(quo_x);
            step_u_ff     <= sat_step(quo_u);
            step_depth_ff <= sat_step(quo_d);
         end
      end
   end

   // row start x magnitude saturates at 2^31
   always_comb begin
      mag = 64'(prod_ff >> (FRAC_BITS + 1));
      if (mag > MAG_LIMIT) begin
         mag = MAG_LIMIT;
      end
   end

   assign setup.busy       = pending_ff | run_ff;
   assign setup.step_x     = step_x_ff;
   assign setup.step_u     = step_u_ff;
   assign setup.step_depth = step_depth_ff;
   assign setup.row_x      = 32'd0 - mag[VAL_W-1:0];

endmodule

[rtl/gmvs_walker.sv]
// ----------------------------------------------------------------------------
// gmvs_walker
// Grid walk state, per-vertex accumulation and the response register.
// ----------------------------------------------------------------------------
module gmvs_walker #(
   parameter int MAX_CUTS  = gmvs_pkg::MAX_CUTS_DEFAULT,
   parameter int FRAC_BITS = gmvs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   gmvs_req_if.sink                 req,
   gmvs_rsp_if.source               rsp,
   input  gmvs_pkg::gmvs_cfg_type   cfg,
   input  gmvs_pkg::gmvs_setup_type setup
);

   import gmvs_pkg::*;

   localparam int EFF_CUTS = (MAX_CUTS < 2**CUTS_W - 1) ? MAX_CUTS : 2**CUTS_W - 1;
   localparam int LAST_W   = $clog2(EFF_CUTS + 2);

   localparam logic [VAL_W-1:0] ONE_STEP     = VAL_W'(1) << FRAC_BITS;
   localparam logic [VAL_W-1:0] HALF_NEG     = 32'd0 - (VAL_W'(1) << (FRAC_BITS - 1));
   localparam logic [VAL_W-1:0] ROW_X_RESET  = 32'd0 - VAL_W'(ASPECT_RESET >> 1);
   localparam logic [VAL_W-1:0] STEP_X_RESET = VAL_W'(ASPECT_RESET);

   logic [LAST_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [VAL_W-1:0]  acc_x_ff, acc_x_in, acc_z_ff, acc_z_in;
   logic [VAL_W-1:0]  acc_u_ff, acc_u_in, acc_v_ff, acc_v_in;
   logic [IDX_W-1:0]  rs_now_ff, rs_now_in, rs_before_ff, rs_before_in;
   logic [IDX_W-1:0]  vtx_ff, vtx_in;
   logic [VAL_W-1:0]  step_x_ff, step_x_in, step_u_ff, step_u_in;
   logic [VAL_W-1:0]  step_d_ff, step_d_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gmvs_result_type   result_ff, result_in;

   logic              accept;
   logic [VAL_W-1:0]  neg_margin;
   logic [LAST_W-1:0] last_col, last_row;
   logic [LAST_W-1:0] cur_col, cur_row;
   logic [VAL_W-1:0]  cur_x, cur_z, cur_u, cur_v;
   logic [IDX_W-1:0]  cur_rs_now, cur_rs_before, cur_vtx, vtx_next;
   logic [VAL_W-1:0]  cur_step_x, cur_step_u, cur_step_d;
   logic              quad, row_end, fin;
   logic [IDX_W-1:0]  col_idx;

   assign req.ready = (!rsp_valid_ff || rsp.ready) && !setup.busy;
   assign accept    = req.valid && req.ready;

   always_comb begin
      neg_margin = 32'd0 - VAL_W'(cfg.repeat_margin);
      last_col   = (32'(cfg.cuts_across) > MAX_CUTS) ? LAST_W'(EFF_CUTS + 1)
                                                    : LAST_W'(cfg.cuts_across) + 1'b1;
      last_row   = (32'(cfg.cuts_deep) > MAX_CUTS) ? LAST_W'(EFF_CUTS + 1)
                                                  : LAST_W'(cfg.cuts_deep) + 1'b1;

      // a restart word walks from a freshly set-up origin
      cur_col       = req.restart ? '0 : col_ff;
      cur_row       = req.restart ? '0 : row_ff;
      cur_x         = req.restart ? setup.row_x : acc_x_ff;
      cur_z         = req.restart ? HALF_NEG : acc_z_ff;
      cur_u         = req.restart ? neg_margin : acc_u_ff;
      cur_v         = req.restart ? '0 : acc_v_ff;
      cur_rs_now    = req.restart ? '0 : rs_now_ff;
      cur_rs_before = req.restart ? '0 : rs_before_ff;
      cur_vtx       = req.restart ? '0 : vtx_ff;
      cur_step_x    = req.restart ? setup.step_x : step_x_ff;
      cur_step_u    = req.restart ? setup.step_u : step_u_ff;
      cur_step_d    = req.restart ? setup.step_depth : step_d_ff;

      quad     = (cur_col != '0) && (cur_row != '0);
      row_end  = (cur_col >= last_col);
      fin      = row_end && (cur_row >= last_row);
      col_idx  = IDX_W'(cur_col);
      vtx_next = cur_vtx + 1'b1;

      result_in.pos_x             = cur_x;
      result_in.pos_z             = cur_z;
      result_in.tex_u             = cur_u;
      result_in.tex_v             = cur_v;
      result_in.vertex_number     = cur_vtx;
      result_in.quad_valid        = quad;
      result_in.corner_prev_left  = quad ? cur_rs_before + col_idx - 1'b1 : '0;
      result_in.corner_prev_right = quad ? cur_rs_before + col_idx : '0;
      result_in.corner_this_left  = quad ? cur_rs_now + col_idx - 1'b1 : '0;
      result_in.corner_this_right = quad ? cur_rs_now + col_idx : '0;
      result_in.final_vertex      = fin;

      if (fin) begin
         // last vertex: set up again from the registers as they stand now
         col_in       = '0;
         row_in       = '0;
         acc_x_in     = setup.row_x;
         acc_z_in     = HALF_NEG;
         acc_u_in     = neg_margin;
         acc_v_in     = '0;
         rs_now_in    = '0;
         rs_before_in = '0;
         vtx_in       = '0;
         step_x_in    = setup.step_x;
         step_u_in    = setup.step_u;
         step_d_in    = setup.step_depth;
      end else begin
         step_x_in    = cur_step_x;
         step_u_in    = cur_step_u;
         step_d_in    = cur_step_d;
         vtx_in       = vtx_next;
         acc_z_in     = cur_z;
         acc_v_in     = cur_v;
         rs_now_in    = cur_rs_now;
         rs_before_in = cur_rs_before;
         row_in       = cur_row;
         if (row_end) begin
            col_in       = '0;
            row_in       = cur_row + 1'b1;
            acc_x_in     = setup.row_x;
            acc_u_in     = neg_margin;
            acc_z_in     = cur_z + cur_step_d;
            acc_v_in     = cur_v + cur_step_d;
            rs_before_in = cur_rs_now;
            rs_now_in    = vtx_next;
         end else begin
            col_in   = cur_col + 1'b1;
            acc_x_in = cur_x + cur_step_x;
            acc_u_in = cur_u + cur_step_u;
         end
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         acc_x_ff     <= ROW_X_RESET;
         acc_z_ff     <= HALF_NEG;
         acc_u_ff     <= '0;
         acc_v_ff     <= '0;
         rs_now_ff    <= '0;
         rs_before_ff <= '0;
         vtx_ff       <= '0;
         step_x_ff    <= STEP_X_RESET;
         step_u_ff    <= ONE_STEP;
         step_d_ff    <= ONE_STEP;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            acc_x_ff     <= acc_x_in;
            acc_z_ff     <= acc_z_in;
            acc_u_ff     <= acc_u_in;
            acc_v_ff     <= acc_v_in;
            rs_now_ff    <= rs_now_in;
            rs_before_ff <= rs_before_in;
            vtx_ff       <= vtx_in;
            step_x_ff    <= step_x_in;
            step_u_ff    <= step_u_in;
            step_d_ff    <= step_d_in;
         end
      end
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.pos_x             = result_ff.pos_x;
   assign rsp.pos_z             = result_ff.pos_z;
   assign rsp.tex_u             = result_ff.tex_u;
   assign rsp.tex_v             = result_ff.tex_v;
   assign rsp.vertex_number     = result_ff.vertex_number;
   assign rsp.quad_valid        = result_ff.quad_valid;
   assign rsp.corner_prev_left  = result_ff.corner_prev_left;
   assign rsp.corner_prev_right = result_ff.corner_prev_right;
   assign rsp.corner_this_left  = result_ff.corner_this_left;
   assign rsp.corner_this_right = result_ff.corner_this_right;
   assign rsp.final_vertex      = result_ff.final_vertex;

endmodule

[tb/grid_mesh_vertex_sequencer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_mesh_vertex_sequencer_unit_tb
// Drives request words into the vertex sequencer and checks every vertex word
// against a local Q16.16 walk of the grid. Register phases are written only
// while the block is quiet. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module grid_mesh_vertex_sequencer_unit_tb;
   import gmvs_pkg::*;

   localparam int FRAC            = FRAC_BITS_DEFAULT;
   localparam int CUTS_MAX        = MAX_CUTS_DEFAULT;
   localparam int RANDOM_VERTICES = 1900;
   localparam int STALL_LIMIT     = 1000;
   localparam int REPORT_LIMIT    = 100;

   typedef enum logic [1:0] {WORK_VERTEX, WORK_REG, WORK_QUIESCE} work_kind_type;
   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CHOKED} sink_style_type;

   typedef struct {
      work_kind_type          kind;
      logic                   restart;
      logic [CSR_INDEX_W-1:0] index;
      logic [CFG_W-1:0]       data;
   } grid_work_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gmvs_req_if req_if ();
   gmvs_rsp_if rsp_if ();
   gmvs_csr_if csr_if ();

   grid_mesh_vertex_sequencer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always #5 clock = ~clock;

   grid_work_type   pending_work[$];
   gmvs_result_type expected_vertices[$];

   logic           req_took = 1'b0;
   logic           csr_took = 1'b0;
   int             gap_left = 0;
   int             burst_left = 1;
   int             style_left = 0;
   sink_style_type sink_style = SINK_OPEN;
   int             quiet_cycles = 0;
   int unsigned    fail_count = 0;

   // register copy and walk state of the grid
   logic [CFG_W-1:0]  cfg_aspect, cfg_margin;
   logic [CUTS_W-1:0] cfg_across, cfg_deep;
   logic [8:0]        walk_col, walk_row;
   logic [VAL_W-1:0]  acc_x, acc_z, acc_u, acc_v;
   logic [VAL_W-1:0]  step_x, step_u, step_depth;
   logic [IDX_W-1:0]  row_now, row_prev, vert_next;

   function automatic int clamp_cuts(int c);
      return (c > CUTS_MAX) ? CUTS_MAX : c;
   endfunction

   function automatic logic [VAL_W-1:0] clip_positive(logic [63:0] v);
      return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[VAL_W-1:0];
   endfunction

   // uv width of one row: 1 + 2r
   function automatic logic [63:0] uv_span();
      return (64'd1 << FRAC) + 64'(cfg_margin) * 64'd2;
   endfunction

   function automatic logic [VAL_W-1:0] row_start_x();
      logic [63:0] mag;
      mag = (64'(cfg_aspect) * uv_span()) >> (FRAC + 1);
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[VAL_W-1:0];
   endfunction

   function automatic void start_grid_walk();
      logic [63:0] across_div, deep_div, prod;
      across_div = 64'(clamp_cuts(int'(cfg_across)) + 1);
      deep_div   = 64'(clamp_cuts(int'(cfg_deep)) + 1);
      prod       = 64'(cfg_aspect) * uv_span();
      step_x     = clip_positive(prod / (across_div << FRAC));
      step_u     = clip_positive(uv_span() / across_div);
      step_depth = clip_positive((64'd1 << FRAC) / deep_div);
      walk_col   = '0;
      walk_row   = '0;
      acc_x      = row_start_x();
      acc_z      = 32'd0 - (32'd1 << (FRAC - 1));
      acc_u      = 32'd0 - 32'(cfg_margin);
      acc_v      = '0;
      row_now    = '0;
      row_prev   = '0;
      vert_next  = '0;
   endfunction

   function automatic void reset_grid_model();
      cfg_aspect = ASPECT_RESET;
      cfg_margin = '0;
      cfg_across = '0;
      cfg_deep   = '0;
      start_grid_walk();
   endfunction

   function automatic void apply_reg_write(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
         CSR_ASPECT:        cfg_aspect = value;
         CSR_REPEAT_MARGIN: cfg_margin = value;
         CSR_CUTS_ACROSS:   cfg_across = value[CUTS_W-1:0];
         CSR_CUTS_DEEP:     cfg_deep = value[CUTS_W-1:0];
         default: ;
      endcase
   endfunction

   // emits the vertex at the walk position, then moves the walk on
   function automatic gmvs_result_type next_grid_vertex(logic restart_flag);
      gmvs_result_type v;
      logic [8:0]      col_limit, row_limit;
      logic            quad, row_done, grid_done;
      if (restart_flag) start_grid_walk();
      col_limit = 9'(clamp_cuts(int'(cfg_across)) + 1);
      row_limit = 9'(clamp_cuts(int'(cfg_deep)) + 1);
      quad      = (walk_col != 0) && (walk_row != 0);
      row_done  = walk_col >= col_limit;
      grid_done = row_done && (walk_row >= row_limit);

      v.pos_x             = acc_x;
      v.pos_z             = acc_z;
      v.tex_u             = acc_u;
      v.tex_v             = acc_v;
      v.vertex_number     = vert_next;
      v.quad_valid        = quad;
      v.corner_prev_left  = quad ? IDX_W'(32'(row_prev) + 32'(walk_col) - 32'd1) : '0;
      v.corner_prev_right = quad ? IDX_W'(32'(row_prev) + 32'(walk_col)) : '0;
      v.corner_this_left  = quad ? IDX_W'(32'(row_now) + 32'(walk_col) - 32'd1) : '0;
      v.corner_this_right = quad ? IDX_W'(32'(row_now) + 32'(walk_col)) : '0;
      v.final_vertex      = grid_done;

      if (grid_done) begin
         start_grid_walk();
      end else begin
         vert_next = vert_next + 1'b1;
         if (row_done) begin
            walk_col = '0;
            walk_row = walk_row + 1'b1;
            acc_x    = row_start_x();
            acc_u    = 32'd0 - 32'(cfg_margin);
            acc_z    = acc_z + step_depth;
            acc_v    = acc_v + step_depth;
            row_prev = row_now;
            row_now  = vert_next;
         end else begin
            walk_col = walk_col + 1'b1;
            acc_x    = acc_x + step_x;
            acc_u    = acc_u + step_u;
         end
      end
      return v;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      end
   endfunction

   task automatic add_vertex(input logic restart_flag);
      grid_work_type w;
      w.kind    = WORK_VERTEX;
      w.restart = restart_flag;
      w.index   = '0;
      w.data    = '0;
      pending_work.push_back(w);
   endtask

   task automatic add_reg_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      grid_work_type w;
      w.kind    = WORK_REG;
      w.restart = 1'b0;
      w.index   = idx;
      w.data    = value;
      pending_work.push_back(w);
   endtask

   task automatic add_quiesce();
      grid_work_type w;
      w.kind    = WORK_QUIESCE;
      w.restart = 1'b0;
      w.index   = '0;
      w.data    = '0;
      pending_work.push_back(w);
   endtask

   function automatic logic [CFG_W-1:0] pick_q8_16();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return ASPECT_RESET;
         3: return CFG_W'($urandom_range(0, 24'h3_FFFF));
         default: return CFG_W'($urandom);
      endcase
   endfunction

   // small grids mostly, so that walks often reach the final vertex
   function automatic logic [CFG_W-1:0] pick_cuts();
      case ($urandom_range(0, 19))
         0: return CFG_W'(255);
         1, 2: return CFG_W'($urandom_range(0, 255));
         default: return CFG_W'($urandom_range(0, 6));
      endcase
   endfunction

   // sender: one word on either the request or the register channel at a time
   always @(negedge clock) begin : feed_proc
      logic                   req_hold, reg_hold, nxt_req_valid, nxt_restart, nxt_reg_valid;
      logic [CSR_INDEX_W-1:0] nxt_index;
      logic [CFG_W-1:0]       nxt_data;
      req_hold      = req_if.valid && !req_took;
      reg_hold      = csr_if.valid && !csr_took;
      nxt_req_valid = req_hold;
      nxt_restart   = req_if.restart;
      nxt_reg_valid = reg_hold;
      nxt_index     = csr_if.index;
      nxt_data      = csr_if.data;
      if (!reset && !req_hold && !reg_hold) begin
         nxt_req_valid = 1'b0;
         nxt_reg_valid = 1'b0;
         nxt_restart   = 1'($urandom_range(0, 1));
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_work.size() != 0) begin
            case (pending_work[0].kind)
               WORK_QUIESCE: begin
                  if (expected_vertices.size() == 0) void'(pending_work.pop_front());
               end
               WORK_REG: begin
                  nxt_reg_valid = 1'b1;
                  nxt_index     = pending_work[0].index;
                  nxt_data      = pending_work[0].data;
                  void'(pending_work.pop_front());
               end
               default: begin
                  nxt_req_valid = 1'b1;
                  nxt_restart   = pending_work[0].restart;
                  void'(pending_work.pop_front());
                  if (burst_left > 1) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 48);
                     gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                  end
               end
            endcase
         end
      end
      req_if.valid   <= nxt_req_valid;
      req_if.restart <= nxt_restart;
      csr_if.valid   <= nxt_reg_valid;
      csr_if.index   <= nxt_index;
      csr_if.data    <= nxt_data;
   end

   // receiver back-pressure, switching style every so often
   always @(negedge clock) begin
      if (style_left == 0) begin
         sink_style = sink_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(16, 160);
      end else begin
         style_left--;
      end
      case (sink_style)
         SINK_OPEN:     rsp_if.ready <= 1'b1;
         SINK_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
         SINK_PERIODIC: rsp_if.ready <= (style_left % 5) != 0;
         default:       rsp_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin : watch_proc
      gmvs_result_type want;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
         reset_grid_model();
      end else begin
         req_took <= req_if.valid && req_if.ready;
         csr_took <= csr_if.valid && csr_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_vertices.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $error("vertex word %0h with no request waiting", rsp_if.vertex_number);
            end else begin
               want = expected_vertices.pop_front();
               check_field("pos_x", want.pos_x, rsp_if.pos_x);
               check_field("pos_z", want.pos_z, rsp_if.pos_z);
               check_field("tex_u", want.tex_u, rsp_if.tex_u);
               check_field("tex_v", want.tex_v, rsp_if.tex_v);
               check_field("vertex_number", want.vertex_number, rsp_if.vertex_number);
               check_field("quad_valid", want.quad_valid, rsp_if.quad_valid);
               check_field("corner_prev_left", want.corner_prev_left, rsp_if.corner_prev_left);
               check_field("corner_prev_right", want.corner_prev_right,
                           rsp_if.corner_prev_right);
               check_field("corner_this_left", want.corner_this_left, rsp_if.corner_this_left);
               check_field("corner_this_right", want.corner_this_right,
                           rsp_if.corner_this_right);
               check_field("final_vertex", want.final_vertex, rsp_if.final_vertex);
            end
         end
         if (csr_if.valid && csr_if.ready) apply_reg_write(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            expected_vertices.push_back(next_grid_vertex(req_if.restart));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int   sent, span, k;
      logic flag;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      rsp_if.ready   = 1'b0;

      // reset grid is 2 x 2: walk it, wrap past the end, then restart mid-walk
      repeat (5) add_vertex(1'b0);
      add_vertex(1'b1);
      add_vertex(1'b0);
      add_vertex(1'b1);

      // widest aspect and margin: x step and row start saturate
      add_quiesce();
      add_reg_write(CSR_ASPECT, '1);
      add_reg_write(CSR_REPEAT_MARGIN, '1);
      add_reg_write(CSR_CUTS_ACROSS, CFG_W'(1));
      add_reg_write(CSR_CUTS_DEEP, CFG_W'(2));
      add_vertex(1'b1);
      repeat (12) add_vertex(1'b0);

      // zero aspect, largest grid
      add_quiesce();
      add_reg_write(CSR_ASPECT, '0);
      add_reg_write(CSR_REPEAT_MARGIN, '0);
      add_reg_write(CSR_CUTS_ACROSS, CFG_W'(255));
      add_reg_write(CSR_CUTS_DEEP, CFG_W'(255));
      add_vertex(1'b1);
      repeat (3) add_vertex(1'b0);

      // grid shrunk under the walk: column past the new row end
      add_quiesce();
      add_reg_write(CSR_CUTS_ACROSS, CFG_W'(1));
      add_reg_write(CSR_CUTS_DEEP, CFG_W'(0));
      repeat (4) add_vertex(1'b0);

      sent = 0;
      while (sent < RANDOM_VERTICES) begin
         add_quiesce();
         if ($urandom_range(0, 1)) add_reg_write(CSR_ASPECT, pick_q8_16());
         if ($urandom_range(0, 1)) add_reg_write(CSR_REPEAT_MARGIN, pick_q8_16());
         if ($urandom_range(0, 1)) add_reg_write(CSR_CUTS_ACROSS, pick_cuts());
         if ($urandom_range(0, 1)) add_reg_write(CSR_CUTS_DEEP, pick_cuts());
         span = $urandom_range(10, 90);
         for (k = 0; k < span; k++) begin
            // mostly a restart to open the phase, rare restarts inside it
            if (k == 0) flag = ($urandom_range(0, 3) != 0);
            else flag = ($urandom_range(0, 39) == 0);
            add_vertex(flag);
            sent++;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (pending_work.size() != 0 || req_if.valid || csr_if.valid ||
                 expected_vertices.size() != 0);
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
